>>> rtl/int_format_string_validator_assert.svh
// ----------------------------------------------------------------------------
// Format string validator assertion macros
// Concurrent assertion wrappers clocked on clk, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef INT_FORMAT_STRING_VALIDATOR_ASSERT_SVH
`define INT_FORMAT_STRING_VALIDATOR_ASSERT_SVH

// Property checked outside reset only.
`define IFV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define IFV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ifv_pkg.sv
// ----------------------------------------------------------------------------
// Format string validator package
// Shared types, character codes, register indexes and the slot limit helper.
// ----------------------------------------------------------------------------
package ifv_pkg;

  localparam int MAX_ARGS_DEF = 16;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ARG_W = 5;
  localparam int MASK_W = 16;
  localparam int NUM_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_ARG_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_MASK = 2'd1;

  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [NUM_W-1:0] NUM_LIMIT = 7'd100;

  typedef enum logic [3:0] {
    PH_LIT   = 4'd0,
    PH_PCT   = 4'd1,
    PH_SIGN  = 4'd2,
    PH_ZERO  = 4'd3,
    PH_WIDTH = 4'd4,
    PH_DOT   = 4'd5,
    PH_PREC  = 4'd6
  } phase_t;

  typedef struct packed {
    logic [ARG_W-1:0]  arg_count;
    logic [MASK_W-1:0] int_slot_mask;
  } cfg_t;

  typedef struct packed {
    logic             ok;
    logic [ARG_W-1:0] count;
  } verdict_t;

  // Clamp the slot count to the largest number of slots the block supports.
  function automatic logic [ARG_W-1:0] slot_limit(input logic [ARG_W-1:0] n,
                                                 input logic [ARG_W:0]   max_args);
    logic [ARG_W:0] n_ext;
    n_ext = {1'b0, n};
    if (n_ext > max_args) begin
      return max_args[ARG_W-1:0];
    end
    return n;
  endfunction

endpackage

>>> rtl/ifv_cfg_regs.sv
// ----------------------------------------------------------------------------
// Format string validator configuration registers
// Holds the slot count and the integer slot mask written over the cfg port.
// ----------------------------------------------------------------------------
module ifv_cfg_regs
  import ifv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  logic [ARG_W-1:0]  arg_count_r;
  logic [MASK_W-1:0] int_slot_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arg_count_r     <= '0;
      int_slot_mask_r <= '0;
    end else if (wr_en) begin
      // unknown indexes are dropped
      if (wr_index == CFG_ARG_COUNT) begin
        arg_count_r <= wr_data[ARG_W-1:0];
      end
      if (wr_index == CFG_INT_MASK) begin
        int_slot_mask_r <= wr_data[MASK_W-1:0];
      end
    end
  end

  assign cfg.arg_count     = arg_count_r;
  assign cfg.int_slot_mask = int_slot_mask_r;

endmodule

>>> rtl/ifv_parser.sv
// ----------------------------------------------------------------------------
// Format string validator parser
// Parse state registers and the per-character transition logic.
// ----------------------------------------------------------------------------
module ifv_parser
  import ifv_pkg::*;
#(
  parameter int MAX_ARGS = MAX_ARGS_DEF
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       char_en,
  input  logic       eos_en,
  input  logic [7:0] ch,
  input  cfg_t       cfg,
  output verdict_t   verdict
);

  localparam logic [ARG_W:0] MaxArgs = (ARG_W+1)'(MAX_ARGS);

  phase_t           phase_r, phase_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [ARG_W-1:0] slot_r, slot_nxt;
  logic             err_r, err_nxt;

  logic [ARG_W-1:0] limit;
  logic             is_dig, is_pct, is_dot, is_d, is_sign, is_zero;
  logic [3:0]       dig;
  logic [10:0]      acc;
  logic             conv_ok;

  assign limit   = slot_limit(cfg.arg_count, MaxArgs);
  assign is_dig  = (ch >= CH_0) && (ch <= CH_9);
  assign is_pct  = (ch == CH_PCT);
  assign is_dot  = (ch == CH_DOT);
  assign is_d    = (ch == CH_D);
  assign is_sign = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign is_zero = (ch == CH_0);
  assign dig     = 4'(ch - CH_0);
  assign acc     = {4'b0, num_r} * 11'd10 + {7'b0, dig};
  // slots of 16 and up are never integer typed
  assign conv_ok = !slot_r[ARG_W-1] && cfg.int_slot_mask[slot_r[ARG_W-2:0]];

  always_comb begin
    phase_nxt = phase_r;
    num_nxt   = num_r;
    slot_nxt  = slot_r;
    err_nxt   = err_r;
    if (eos_en) begin
      phase_nxt = PH_LIT;
      num_nxt   = '0;
      slot_nxt  = '0;
      err_nxt   = 1'b0;
    end else if (char_en && !err_r) begin
      unique case (phase_r)
        PH_PCT, PH_SIGN, PH_ZERO, PH_WIDTH: begin
          priority if (phase_r == PH_PCT && is_pct) begin
            phase_nxt = PH_LIT;
          end else if (phase_r == PH_PCT && slot_r >= limit) begin
            err_nxt = 1'b1;
          end else if (phase_r == PH_PCT && is_sign) begin
            phase_nxt = PH_SIGN;
          end else if ((phase_r == PH_PCT || phase_r == PH_SIGN) && is_zero) begin
            phase_nxt = PH_ZERO;
          end else if (phase_r != PH_WIDTH && is_dig) begin
            num_nxt   = {3'b0, dig};
            phase_nxt = PH_WIDTH;
          end else if (phase_r == PH_WIDTH && is_dig) begin
            if (acc > {4'b0, NUM_LIMIT}) begin
              err_nxt = 1'b1;
            end else begin
              num_nxt = acc[NUM_W-1:0];
            end
          end else if (is_dot) begin
            phase_nxt = PH_DOT;
          end else if (is_d && conv_ok) begin
            slot_nxt  = slot_r + 1'b1;
            phase_nxt = PH_LIT;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_DOT: begin
          if (is_dig) begin
            num_nxt   = {3'b0, dig};
            phase_nxt = PH_PREC;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_PREC: begin
          priority if (is_dig) begin
            if (acc > {4'b0, NUM_LIMIT}) begin
              err_nxt = 1'b1;
            end else begin
              num_nxt = acc[NUM_W-1:0];
            end
          end else if (is_d && conv_ok) begin
            slot_nxt  = slot_r + 1'b1;
            phase_nxt = PH_LIT;
          end else begin
            err_nxt = 1'b1;
          end
        end
        default: begin
          phase_nxt = is_pct ? PH_PCT : PH_LIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LIT;
      num_r   <= '0;
      slot_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      num_r   <= num_nxt;
      slot_r  <= slot_nxt;
      err_r   <= err_nxt;
    end
  end

  assign verdict.ok    = !err_r && (phase_r == PH_LIT) && (slot_r == limit);
  assign verdict.count = slot_r;

endmodule

>>> rtl/int_format_string_validator.sv
// ----------------------------------------------------------------------------
// Integer format string validator
// Checks a printf-style format string one character per transaction.
// ----------------------------------------------------------------------------
// One character transaction is taken every clock cycle, back to back, while
// in_stall is low. Each transaction lands in an input register; from there it
// steps the parse state (a loop through the phase, number, slot and error
// registers) and, for an end-of-string transaction, loads the verdict into
// the result register, so a verdict passes the input and result registers
// in turn. Character transactions produce no result. in_stall rises only
// while an end-of-string transaction waits behind a result that out_stall is
// holding. Write cfg registers only while no transaction is in flight.
module int_format_string_validator
  import ifv_pkg::*;
#(
  parameter int MAX_ARGS = MAX_ARGS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // character channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [7:0]            in_ch,
  // verdict channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_valid_res,
  output logic [ARG_W-1:0]      out_conversions_seen,
  // register write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "int_format_string_validator_assert.svh"

  localparam logic [ARG_W:0] MaxArgs = (ARG_W+1)'(MAX_ARGS);

  // input register
  logic       item_valid_r, item_valid_nxt;
  logic       action_r;
  logic [7:0] ch_r;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic             res_ok_r;
  logic [ARG_W-1:0] res_count_r;

  logic     in_accept;
  logic     out_free;
  logic     proc;
  logic     out_load;
  cfg_t     cfg;
  verdict_t verdict;

  assign cfg_ready = 1'b1;

  // Result register can take a verdict when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  // Characters always advance; end of string waits for a free result slot.
  assign proc     = item_valid_r && (!action_r || out_free);
  assign out_load = proc && action_r;

  assign in_stall  = item_valid_r && !proc;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_accept) begin
      item_valid_nxt = 1'b1;
    end else if (proc) begin
      item_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers: hold unless loaded
  always_ff @(posedge clk) begin
    if (in_accept) begin
      action_r <= in_action;
      ch_r     <= in_ch;
    end
    if (out_load) begin
      res_ok_r    <= verdict.ok;
      res_count_r <= verdict.count;
    end
  end

  ifv_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // End of string reports the current state, then clears it for the next string.
  ifv_parser #(
    .MAX_ARGS (MAX_ARGS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .char_en (proc && !action_r),
    .eos_en  (out_load),
    .ch      (ch_r),
    .cfg     (cfg),
    .verdict (verdict)
  );

  assign out_valid            = out_valid_r;
  assign out_valid_res        = res_ok_r;
  assign out_conversions_seen = res_count_r;

  // An empty input register never stalls the character channel.
  `IFV_ASSERT_ALWAYS(a_no_stall_when_empty, !item_valid_r |-> !in_stall, "stall with empty input register")
  // A processed end of string always produces a verdict.
  `IFV_ASSERT(a_eos_gives_result, out_load |=> out_valid_r, "end of string lost")
  // The count never exceeds the supported slots.
  `IFV_ASSERT(a_count_bound, out_valid_r |-> ({1'b0, out_conversions_seen} <= MaxArgs), "count beyond slot range")
  // A passing verdict carries exactly the configured number of conversions.
  `IFV_ASSERT(a_pass_count, out_valid_r && out_valid_res |-> out_conversions_seen == slot_limit(cfg.arg_count, MaxArgs), "pass with wrong count")

endmodule
